// File: hw/rtl/circular_event_log_top_macros.svh
// assertion helpers used by the checker file
`ifndef CIRCULAR_EVENT_LOG_TOP_MACROS_SVH
`define CIRCULAR_EVENT_LOG_TOP_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define CEL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define CEL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/cel_pkg.sv
`timescale 1ns / 1ps

package cel_pkg;

   typedef enum logic {
      FUNC_RECORD = 1'b0,
      FUNC_READ   = 1'b1
   } func_type;

   // one ring slot as it sits in memory
   typedef struct packed {
      logic [7:0]  category;
      logic [15:0] code;
      logic [31:0] sequence_num;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// File: hw/rtl/cel_if.sv
`timescale 1ns / 1ps

interface cel_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] event_category;
   logic [15:0] event_code;
   logic [7:0] read_index;

   modport source (output valid, func, event_category, event_code, read_index,
                   input ready);
   modport sink (input valid, func, event_category, event_code, read_index,
                 output ready);
endinterface

interface cel_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [7:0]  out_category;
   logic [15:0] out_code;
   logic [31:0] seq_number;
   logic [31:0] total_count;
   logic [7:0]  visible_count;

   modport source (output valid, hit, out_category, out_code, seq_number,
                   total_count, visible_count, input ready);
   modport sink (input valid, hit, out_category, out_code, seq_number,
                 total_count, visible_count, output ready);
endinterface

// File: hw/rtl/circular_event_log_top.sv
`timescale 1ns / 1ps
// a request word passes the pending stage and then the output register before its result word is offered
// throughput: one request word per cycle while the response side keeps ready high
// the slot memory has one write and one read port: a record writes, a read that hits reads, one per item
// reset clears the pointer, the running total and both valid flags
// slot memory is not cleared: no slot can be read before it has been written

module circular_event_log_top #(
   parameter int RING_DEPTH = 16
) (
   input logic    clock,
   input logic    reset,
   cel_req_if.sink   req_ch,
   cel_rsp_if.source rsp_ch
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_SLOT = AW'(RING_DEPTH - 1);
   localparam logic [31:0]   DEPTH_32  = 32'(RING_DEPTH);
   localparam logic [8:0]    DEPTH_9   = 9'(RING_DEPTH);
   localparam logic [7:0]    DEPTH_8   = 8'(RING_DEPTH);

   // ring state
   logic [AW-1:0] wp_ff, wp_in;
   logic [31:0]   total_ff, total_in;

   // pending stage: one item whose memory read may be in flight
   logic          pend_valid_ff, pend_valid_in;
   logic          pend_read_ff;
   logic          pend_hit_ff;
   logic [7:0]    pend_cat_ff;
   logic [15:0]   pend_code_ff;
   logic [31:0]   pend_seq_ff;
   logic [31:0]   pend_total_ff;
   logic [7:0]    pend_vis_ff;

   // output register
   logic          out_valid_ff, out_valid_in;
   logic          out_hit_ff;
   logic [7:0]    out_cat_ff;
   logic [15:0]   out_code_ff;
   logic [31:0]   out_seq_ff;
   logic [31:0]   out_total_ff;
   logic [7:0]    out_vis_ff;

   logic          pend_adv;
   logic          accept;
   logic          is_record;
   logic [31:0]   total_inc;
   logic [7:0]    vis_now;
   logic [7:0]    vis_after;
   logic          read_hit;
   logic [AW-1:0] oldest;
   logic [8:0]    idx_sum;
   logic [8:0]    idx_wrap;
   logic [AW-1:0] rd_slot;

   cel_pkg::entry_type wr_entry;
   cel_pkg::entry_type rd_entry;
   logic [cel_pkg::ENTRY_W-1:0] rd_raw;

   // visible count saturates at the ring size
   function automatic logic [7:0] vis_of(input logic [31:0] total);
      logic [7:0] vis;
      vis = (total >= DEPTH_32) ? DEPTH_8 : total[7:0];
      return vis;
   endfunction

   // handshake: pending stage drains when the output register is free or being taken
   assign pend_adv     = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !pend_valid_ff || pend_adv;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_record    = (req_ch.func == cel_pkg::FUNC_RECORD);

   assign total_inc = total_ff + 32'd1;
   assign vis_now   = vis_of(total_ff);
   assign vis_after = vis_of(total_inc);
   assign read_hit  = (req_ch.read_index < vis_now);

   // oldest slot is zero until the ring has wrapped, then the write pointer
   assign oldest   = (total_ff <= DEPTH_32) ? '0 : wp_ff;
   assign idx_sum  = {{(9 - AW){1'b0}}, oldest} + {1'b0, req_ch.read_index};
   assign idx_wrap = (idx_sum >= DEPTH_9) ? (idx_sum - DEPTH_9) : idx_sum;
   assign rd_slot  = idx_wrap[AW-1:0];

   assign wr_entry.category     = req_ch.event_category;
   assign wr_entry.code         = req_ch.event_code;
   assign wr_entry.sequence_num = total_inc;

   // record writes at accept; a read issued in a later cycle already sees it
   cel_ram #(
      .WIDTH(cel_pkg::ENTRY_W),
      .DEPTH(RING_DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (accept && is_record),
      .wr_addr (wp_ff),
      .wr_data (wr_entry),
      .rd_en   (accept && !is_record && read_hit),
      .rd_addr (rd_slot),
      .rd_data (rd_raw)
   );

   assign rd_entry = cel_pkg::entry_type'(rd_raw);

   always_comb begin
      wp_in    = wp_ff;
      total_in = total_ff;
      if (accept && is_record) begin
         total_in = total_inc;
         wp_in    = (wp_ff == LAST_SLOT) ? '0 : wp_ff + AW'(1);
      end
   end

   always_comb begin
      if (accept) begin
         pend_valid_in = 1'b1;
      end else if (pend_adv) begin
         pend_valid_in = 1'b0;
      end else begin
         pend_valid_in = pend_valid_ff;
      end
      out_valid_in = pend_adv ? pend_valid_ff : 1'b1;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff         <= '0;
         total_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         wp_ff         <= wp_in;
         total_ff      <= total_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   // pending payload; a miss carries zero fields
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_read_ff <= !is_record;
         if (is_record) begin
            pend_hit_ff   <= 1'b1;
            pend_cat_ff   <= req_ch.event_category;
            pend_code_ff  <= req_ch.event_code;
            pend_seq_ff   <= total_inc;
            pend_total_ff <= total_inc;
            pend_vis_ff   <= vis_after;
         end else begin
            pend_hit_ff   <= read_hit;
            pend_cat_ff   <= '0;
            pend_code_ff  <= '0;
            pend_seq_ff   <= '0;
            pend_total_ff <= total_ff;
            pend_vis_ff   <= vis_now;
         end
      end
   end

   // output payload: read hits take the slot memory data
   always_ff @(posedge clock) begin
      if (pend_adv && pend_valid_ff) begin
         out_hit_ff   <= pend_hit_ff;
         out_total_ff <= pend_total_ff;
         out_vis_ff   <= pend_vis_ff;
         if (pend_read_ff && pend_hit_ff) begin
            out_cat_ff  <= rd_entry.category;
            out_code_ff <= rd_entry.code;
            out_seq_ff  <= rd_entry.sequence_num;
         end else begin
            out_cat_ff  <= pend_cat_ff;
            out_code_ff <= pend_code_ff;
            out_seq_ff  <= pend_seq_ff;
         end
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.hit           = out_hit_ff;
   assign rsp_ch.out_category  = out_cat_ff;
   assign rsp_ch.out_code      = out_code_ff;
   assign rsp_ch.seq_number    = out_seq_ff;
   assign rsp_ch.total_count   = out_total_ff;
   assign rsp_ch.visible_count = out_vis_ff;

endmodule

// File: hw/rtl/cel_ram.sv
`timescale 1ns / 1ps

module cel_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cel_checker.sv
`timescale 1ns / 1ps
`include "circular_event_log_top_macros.svh"

module cel_checker #(
   parameter int RING_DEPTH = 16
) (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_hit,
   input logic [7:0]  rsp_category,
   input logic [15:0] rsp_code,
   input logic [31:0] rsp_seq,
   input logic [31:0] rsp_total,
   input logic [7:0]  rsp_visible
);

   localparam logic [31:0] DEPTH_32 = 32'(RING_DEPTH);
   localparam logic [7:0]  DEPTH_8  = 8'(RING_DEPTH);

   // stalled response word holds
   `CEL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_seq) && $stable(rsp_total) && $stable(rsp_hit), "response word changed while stalled")

   // a miss reports zero entry fields
   `CEL_ASSERT_NOW(a_miss_zero, rsp_valid && !rsp_hit, rsp_seq == 32'd0 && rsp_category == 8'd0 && rsp_code == 16'd0, "miss carries nonzero entry fields")

   // visible count follows the total, saturating at the ring size
   `CEL_ASSERT_NOW(a_vis_sat, rsp_valid && rsp_total >= DEPTH_32, rsp_visible == DEPTH_8, "visible count not saturated")
   `CEL_ASSERT_NOW(a_vis_low, rsp_valid && rsp_total < DEPTH_32, rsp_visible == rsp_total[7:0], "visible count differs from total")

endmodule

bind circular_event_log_top cel_checker #(
   .RING_DEPTH(RING_DEPTH)
) u_cel_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_hit      (rsp_ch.hit),
   .rsp_category (rsp_ch.out_category),
   .rsp_code     (rsp_ch.out_code),
   .rsp_seq      (rsp_ch.seq_number),
   .rsp_total    (rsp_ch.total_count),
   .rsp_visible  (rsp_ch.visible_count)
);
